/* hw/rtl/bpwp_pkg.sv */
// Shared types and constants for the breakpoint/watchpoint run-control block.
// Used by bpwp_cell, bpwp_run_ctl and breakpoint_watchpoint_run_control.
// No dependencies.
package bpwp_pkg;

  localparam int ENTRIES   = 16;
  localparam int ADDR_W    = 24;
  localparam int CNT_W     = 24;
  localparam int HITS_W    = 16;
  localparam int SRC_W     = 4;
  localparam int DATA_W    = 8;
  localparam int OUT_IDX_W = 4;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // common width for comparing the 4-bit slot number against a cell id
  localparam int CMP_W     = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [SRC_W-1:0] SRC_CPU = 4'd0;
  localparam logic [SRC_W-1:0] SRC_SMP = 4'd1;
  localparam logic [SRC_W-1:0] SRC_APU = 4'd4;

  typedef enum logic [1:0] {
    OP_ACCESS      = 2'd0,
    OP_WRITE_ENTRY = 2'd1,
    OP_ARM         = 2'd2,
    OP_STOP_ALL    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DISABLED = 2'd0,
    KIND_READ     = 2'd1,
    KIND_WRITE    = 2'd2,
    KIND_EXEC     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_RUN_FOR  = 2'd0,
    MODE_RUN_TO   = 2'd1,
    MODE_STEP_FOR = 2'd2,
    MODE_STEP_TO  = 2'd3
  } run_mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // entry write broadcast to every cell
  typedef struct packed {
    logic              we;
    logic [OUT_IDX_W-1:0] index;
    logic [SRC_W-1:0]  source;
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              dce;
  } entry_wr_t;

  // event travelling down the chain, collecting the first primary and alias hit
  typedef struct packed {
    logic              valid;
    logic [SRC_W-1:0]  src;
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              alias_en;
    logic              h_found;
    logic [IDX_W-1:0]  h_idx;
    logic [HITS_W-1:0] h_cnt;
    logic              a_found;
    logic [IDX_W-1:0]  a_idx;
    logic [HITS_W-1:0] a_cnt;
  } token_t;

  typedef struct packed {
    logic              arm;
    logic              stop;
    logic              proc;
    run_mode_t         mode;
    logic [CNT_W-1:0]  value;
  } rc_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              exec_proc;
    logic              proc;
    logic              any_hit;
    logic [ADDR_W-1:0] addr;
  } rc_evt_t;

  typedef struct packed {
    logic halt;
    logic trace;
  } rc_res_t;

endpackage

/* hw/rtl/breakpoint_watchpoint_run_control.sv */
// Breakpoint/watchpoint table with per-processor run control, top level.
// Depends on bpwp_pkg, bpwp_cell and bpwp_run_ctl.
//
// An access event walks the chain of ENTRIES table cells one cell per clock,
// so busy stays high during the walk and the result appears in the cycle
// after it ends; the next start can be taken in the cycle that result is
// shown. Entry writes, arms, stop-all, suppressed events and disabled-kind
// events skip the walk; their registered result appears in the cycle after
// the start transfer. Each result is held for exactly one cycle under done;
// there is no back-pressure, so the receiver must take it then. The config
// register may be written at any time (cfg_ready is always high).
module breakpoint_watchpoint_run_control
  import bpwp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation,
  input  logic [SRC_W-1:0]     source,
  input  logic [1:0]           access_kind,
  input  logic [ADDR_W-1:0]    address,
  input  logic [DATA_W-1:0]    data_value,
  input  logic                 data_compare_enable,
  input  logic [OUT_IDX_W-1:0] entry_index,
  input  logic [1:0]           run_mode,
  input  logic [CNT_W-1:0]     run_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  output logic                 done,
  output logic                 halt,
  output logic                 trace_request,
  output logic                 hit,
  output logic [OUT_IDX_W-1:0] hit_index,
  output logic [HITS_W-1:0]    hit_count,
  output logic                 alias_hit,
  output logic [OUT_IDX_W-1:0] alias_index,
  output logic [HITS_W-1:0]    alias_count
);

  state_t    state, state_next;
  logic      suppress;
  logic      accept;
  logic      launch;
  logic      finish;
  op_t       op;
  kind_t     kind;
  entry_wr_t wr;
  rc_cmd_t   cmd;
  rc_evt_t   evt;
  rc_res_t   rc_res;
  token_t    chain [ENTRIES+1];
  token_t    last;

  assign op        = op_t'(operation);
  assign kind      = kind_t'(access_kind);
  assign busy      = (state == ST_WALK);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign last      = chain[ENTRIES];
  assign finish    = (state == ST_WALK) && last.valid;
  assign launch    = accept && (op == OP_ACCESS) && !suppress && (kind != KIND_DISABLED);

  always_ff @(posedge clk) begin
    if (rst) begin
      suppress <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      suppress <= cfg_data;
    end
  end

  always_comb begin
    chain[0]          = '0;
    chain[0].valid    = launch;
    chain[0].src      = source;
    chain[0].kind     = kind;
    chain[0].addr     = address;
    chain[0].data     = data_value;
    chain[0].alias_en = (source == SRC_SMP) &&
                        ((kind == KIND_READ) || (kind == KIND_WRITE));
  end

  always_comb begin
    wr.we     = accept && (op == OP_WRITE_ENTRY);
    wr.index  = entry_index;
    wr.source = source;
    wr.kind   = kind;
    wr.addr   = address;
    wr.data   = data_value;
    wr.dce    = data_compare_enable;
  end

  always_comb begin
    cmd.stop  = accept && (op == OP_STOP_ALL);
    cmd.arm   = accept && (op == OP_ARM) && (source <= SRC_SMP);
    cmd.proc  = source[0];
    cmd.mode  = run_mode_t'(run_mode);
    cmd.value = run_value;
  end

  always_comb begin
    evt.valid     = finish;
    evt.exec_proc = (last.kind == KIND_EXEC) && (last.src <= SRC_SMP);
    evt.proc      = last.src[0];
    evt.any_hit   = last.h_found || last.a_found;
    evt.addr      = last.addr;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bpwp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (IDX_W'(i)),
      .wr      (wr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  bpwp_run_ctl u_run_ctl (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .evt (evt),
    .res (rc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (launch) state_next = ST_WALK;
      ST_WALK: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish || (accept && !launch);
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      halt          <= rc_res.halt;
      trace_request <= rc_res.trace;
      hit           <= last.h_found;
      hit_index     <= OUT_IDX_W'(last.h_idx);
      hit_count     <= last.h_cnt;
      alias_hit     <= last.a_found;
      alias_index   <= OUT_IDX_W'(last.a_idx);
      alias_count   <= last.a_cnt;
    end else if (accept) begin
      halt          <= (op == OP_STOP_ALL);
      trace_request <= 1'b0;
      hit           <= 1'b0;
      hit_index     <= '0;
      hit_count     <= '0;
      alias_hit     <= 1'b0;
      alias_index   <= '0;
      alias_count   <= '0;
    end
  end

endmodule

/* hw/rtl/bpwp_cell.sv */
// One breakpoint table entry plus one stage of the match chain.
// Depends on bpwp_pkg.
module bpwp_cell
  import bpwp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  entry_wr_t        wr,
  input  token_t           tok_in,
  output token_t           tok_out
);

  logic [SRC_W-1:0]  e_source;
  kind_t             e_kind;
  logic [ADDR_W-1:0] e_address;
  logic [DATA_W-1:0] e_data;
  logic              e_dce;
  logic [HITS_W-1:0] hits;

  logic              base_match;
  logic              prim_match;
  logic              alias_match;
  logic              sel;
  logic [HITS_W-1:0] hits_inc;
  token_t            tok_next;

  assign sel = wr.we && (CMP_W'(wr.index) == CMP_W'(cell_id));

  // data compare only applies to read and write entries
  assign base_match = tok_in.valid && (e_kind == tok_in.kind) &&
                      (e_address == tok_in.addr) &&
                      ((tok_in.kind == KIND_EXEC) || !e_dce || (e_data == tok_in.data));
  assign prim_match  = base_match && (e_source == tok_in.src) && !tok_in.h_found;
  assign alias_match = base_match && tok_in.alias_en && (e_source == SRC_APU) &&
                       !tok_in.a_found;
  assign hits_inc    = (hits == HITS_MAX) ? hits : hits + 1'b1;

  always_comb begin
    tok_next = tok_in;
    if (prim_match) begin
      tok_next.h_found = 1'b1;
      tok_next.h_idx   = cell_id;
      tok_next.h_cnt   = hits_inc;
    end
    if (alias_match) begin
      tok_next.a_found = 1'b1;
      tok_next.a_idx   = cell_id;
      tok_next.a_cnt   = hits_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_kind <= KIND_DISABLED;
    end else if (sel) begin
      e_kind <= wr.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      e_source  <= wr.source;
      e_address <= wr.addr;
      e_data    <= wr.data;
      e_dce     <= wr.dce;
      hits      <= '0;
    end else if (prim_match || alias_match) begin
      hits <= hits_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* hw/rtl/bpwp_run_ctl.sv */
// Run-for, run-to, step-for and step-to controls of the two processors.
// Depends on bpwp_pkg.
module bpwp_run_ctl
  import bpwp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  rc_cmd_t cmd,
  input  rc_evt_t evt,
  output rc_res_t res
);

  logic              rf_armed [2];
  logic [CNT_W-1:0]  rf_count [2];
  logic              rt_armed [2];
  logic [ADDR_W-1:0] rt_target [2];
  logic              sf_armed [2];
  logic [CNT_W-1:0]  sf_count [2];
  logic              st_armed [2];
  logic [ADDR_W-1:0] st_target [2];

  logic              rf_armed_next [2];
  logic [CNT_W-1:0]  rf_count_next [2];
  logic              rt_armed_next [2];
  logic [ADDR_W-1:0] rt_target_next [2];
  logic              sf_armed_next [2];
  logic [CNT_W-1:0]  sf_count_next [2];
  logic              st_armed_next [2];
  logic [ADDR_W-1:0] st_target_next [2];

  logic              p;
  logic [CNT_W-1:0]  rf_dec;
  logic [CNT_W-1:0]  sf_dec;
  logic              clear_all;

  assign p      = evt.proc;
  assign rf_dec = rf_count[p] - 1'b1;
  assign sf_dec = sf_count[p] - 1'b1;

  always_comb begin
    rf_armed_next  = rf_armed;
    rf_count_next  = rf_count;
    rt_armed_next  = rt_armed;
    rt_target_next = rt_target;
    sf_armed_next  = sf_armed;
    sf_count_next  = sf_count;
    st_armed_next  = st_armed;
    st_target_next = st_target;
    res            = '0;
    clear_all      = 1'b0;

    if (cmd.stop) begin
      clear_all = 1'b1;
    end else if (cmd.arm) begin
      unique case (cmd.mode)
        MODE_RUN_FOR: begin
          rf_armed_next[cmd.proc] = 1'b1;
          rf_count_next[cmd.proc] = cmd.value;
        end
        MODE_RUN_TO: begin
          rt_armed_next[cmd.proc]  = 1'b1;
          rt_target_next[cmd.proc] = ADDR_W'(cmd.value);
        end
        MODE_STEP_FOR: begin
          sf_armed_next[cmd.proc] = 1'b1;
          sf_count_next[cmd.proc] = cmd.value;
        end
        MODE_STEP_TO: begin
          st_armed_next[cmd.proc]  = 1'b1;
          st_target_next[cmd.proc] = ADDR_W'(cmd.value);
        end
        default: ;
      endcase
    end else if (evt.valid) begin
      if (evt.any_hit) begin
        res.halt  = 1'b1;
        res.trace = evt.exec_proc;
      end else if (evt.exec_proc) begin
        // first halt ends the sequence
        if (rf_armed[p]) begin
          rf_count_next[p] = rf_dec;
          if (rf_dec == '0) begin
            res.halt  = 1'b1;
            res.trace = 1'b1;
          end
        end
        if (!res.halt && rt_armed[p] && (evt.addr == rt_target[p])) begin
          res.halt  = 1'b1;
          res.trace = 1'b1;
        end
        if (!res.halt && sf_armed[p]) begin
          res.trace        = 1'b1;
          sf_count_next[p] = sf_dec;
          if (sf_dec == '0) res.halt = 1'b1;
        end
        if (!res.halt && st_armed[p]) begin
          res.trace = 1'b1;
          if (evt.addr == st_target[p]) res.halt = 1'b1;
        end
      end
      clear_all = res.halt;
    end

    if (clear_all) begin
      for (int i = 0; i < 2; i++) begin
        rf_armed_next[i] = 1'b0;
        rt_armed_next[i] = 1'b0;
        sf_armed_next[i] = 1'b0;
        st_armed_next[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        rf_armed[i] <= 1'b0;
        rt_armed[i] <= 1'b0;
        sf_armed[i] <= 1'b0;
        st_armed[i] <= 1'b0;
      end
    end else begin
      rf_armed <= rf_armed_next;
      rt_armed <= rt_armed_next;
      sf_armed <= sf_armed_next;
      st_armed <= st_armed_next;
    end
  end

  always_ff @(posedge clk) begin
    rf_count  <= rf_count_next;
    rt_target <= rt_target_next;
    sf_count  <= sf_count_next;
    st_target <= st_target_next;
  end

endmodule

/* tb/sv/tb_breakpoint_watchpoint_run_control.sv */
// Self-checking testbench for breakpoint_watchpoint_run_control.
// Runs a directed table and then random phases, checking each result against a model or typed want.
// Depends on bpwp_pkg and the RTL of the block.
module tb_breakpoint_watchpoint_run_control
  import bpwp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int HIT_REPEATS  = 40;
  localparam int N_PHASES     = 4;
  localparam int PHASE_IDLE  [N_PHASES] = '{0, 87, 36, 36};
  localparam int PHASE_ITEMS [N_PHASES] = '{200, 180, 60, 200};
  localparam bit PHASE_SUP   [N_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0};

  typedef struct packed {
    op_t                  op;
    logic [SRC_W-1:0]     source;
    kind_t                kind;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    data;
    logic                 dce;
    logic [OUT_IDX_W-1:0] entry_index;
    run_mode_t            mode;
    logic [CNT_W-1:0]     value;
  } mon_cmd_t;

  typedef struct packed {
    logic                 halt;
    logic                 trace;
    logic                 hit;
    logic [OUT_IDX_W-1:0] hit_index;
    logic [HITS_W-1:0]    hit_count;
    logic                 alias_hit;
    logic [OUT_IDX_W-1:0] alias_index;
    logic [HITS_W-1:0]    alias_count;
  } mon_result_t;

  typedef struct {
    mon_cmd_t    cmd;
    logic        sup;
    int          reps;
    logic        typed;
    mon_result_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;
  logic done;
  logic halt;
  logic trace_request;
  logic hit;
  logic [OUT_IDX_W-1:0] hit_index;
  logic [HITS_W-1:0]    hit_count;
  logic alias_hit;
  logic [OUT_IDX_W-1:0] alias_index;
  logic [HITS_W-1:0]    alias_count;

  // command on the ports, plus an optional hand-typed expectation for it
  mon_cmd_t    cur_cmd;
  logic        cur_typed;
  mon_result_t cur_want;

  // monitor model state
  logic [SRC_W-1:0]  bp_source [ENTRIES];
  kind_t             bp_kind   [ENTRIES];
  logic [ADDR_W-1:0] bp_addr   [ENTRIES];
  logic [DATA_W-1:0] bp_data   [ENTRIES];
  logic              bp_dce    [ENTRIES];
  logic [HITS_W-1:0] bp_hits   [ENTRIES];
  logic              rf_on   [2];
  logic [CNT_W-1:0]  rf_cnt  [2];
  logic              rt_on   [2];
  logic [ADDR_W-1:0] rt_addr [2];
  logic              sf_on   [2];
  logic [CNT_W-1:0]  sf_cnt  [2];
  logic              st_on   [2];
  logic [ADDR_W-1:0] st_addr [2];
  logic              suppress_q;

  mon_result_t expected_results [$];
  dir_row_t    dir_rows [$];

  logic [ADDR_W-1:0] addr_pool [4];
  logic [DATA_W-1:0] data_pool [3];
  logic              sup_now;

  int mismatches;
  int stall_cycles;
  int n_access, n_writes, n_arms, n_stops;
  int n_halts, n_traces, n_hits, n_alias, n_sat;

  breakpoint_watchpoint_run_control i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .operation           (cur_cmd.op),
    .source              (cur_cmd.source),
    .access_kind         (cur_cmd.kind),
    .address             (cur_cmd.address),
    .data_value          (cur_cmd.data),
    .data_compare_enable (cur_cmd.dce),
    .entry_index         (cur_cmd.entry_index),
    .run_mode            (cur_cmd.mode),
    .run_value           (cur_cmd.value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .done                (done),
    .halt                (halt),
    .trace_request       (trace_request),
    .hit                 (hit),
    .hit_index           (hit_index),
    .hit_count           (hit_count),
    .alias_hit           (alias_hit),
    .alias_index         (alias_index),
    .alias_count         (alias_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_run_controls();
    for (int p = 0; p < 2; p++) begin
      rf_on[p] = 1'b0; rf_cnt[p] = '0;
      rt_on[p] = 1'b0; rt_addr[p] = '0;
      sf_on[p] = 1'b0; sf_cnt[p] = '0;
      st_on[p] = 1'b0; st_addr[p] = '0;
    end
  endfunction

  // lowest matching entry, bumping its saturating hit count; -1 if none
  function automatic int match_entry(input logic [SRC_W-1:0] s, input kind_t k,
                                     input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    for (int i = 0; i < ENTRIES; i++) begin
      if (bp_source[i] == s && bp_kind[i] == k && bp_addr[i] == a &&
          (k == KIND_EXEC || !bp_dce[i] || bp_data[i] == d)) begin
        if (bp_hits[i] != HITS_MAX) bp_hits[i] = bp_hits[i] + 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic mon_result_t predict_monitor(input mon_cmd_t c);
    mon_result_t r;
    int          h;
    int          a;
    int          p;
    logic        exec_proc;
    r = '0;
    h = -1;
    a = -1;
    case (c.op)
      OP_WRITE_ENTRY: begin
        if (int'(c.entry_index) < ENTRIES) begin
          bp_source[c.entry_index] = c.source;
          bp_kind[c.entry_index]   = c.kind;
          bp_addr[c.entry_index]   = c.address;
          bp_data[c.entry_index]   = c.data;
          bp_dce[c.entry_index]    = c.dce;
          bp_hits[c.entry_index]   = '0;
        end
      end
      OP_ARM: begin
        if (c.source <= SRC_SMP) begin
          p = int'(c.source);
          case (c.mode)
            MODE_RUN_FOR:  begin rf_on[p] = 1'b1; rf_cnt[p] = c.value; end
            MODE_RUN_TO:   begin rt_on[p] = 1'b1; rt_addr[p] = c.value[ADDR_W-1:0]; end
            MODE_STEP_FOR: begin sf_on[p] = 1'b1; sf_cnt[p] = c.value; end
            default:       begin st_on[p] = 1'b1; st_addr[p] = c.value[ADDR_W-1:0]; end
          endcase
        end
      end
      OP_STOP_ALL: begin
        clear_run_controls();
        r.halt = 1'b1;
      end
      default: begin
        if (!suppress_q && c.kind != KIND_DISABLED) begin
          h = match_entry(c.source, c.kind, c.address, c.data);
          if (c.source == SRC_SMP && (c.kind == KIND_READ || c.kind == KIND_WRITE))
            a = match_entry(SRC_APU, c.kind, c.address, c.data);
          exec_proc = (c.kind == KIND_EXEC) && (c.source <= SRC_SMP);
          if (h >= 0 || a >= 0) begin
            r.halt  = 1'b1;
            r.trace = exec_proc;
          end else if (exec_proc) begin
            p = int'(c.source);
            if (rf_on[p]) begin
              rf_cnt[p] = rf_cnt[p] - 1'b1;
              if (rf_cnt[p] == '0) begin r.halt = 1'b1; r.trace = 1'b1; end
            end
            if (!r.halt && rt_on[p] && c.address == rt_addr[p]) begin
              r.halt = 1'b1; r.trace = 1'b1;
            end
            if (!r.halt && sf_on[p]) begin
              r.trace = 1'b1;
              sf_cnt[p] = sf_cnt[p] - 1'b1;
              if (sf_cnt[p] == '0) r.halt = 1'b1;
            end
            if (!r.halt && st_on[p]) begin
              r.trace = 1'b1;
              if (c.address == st_addr[p]) r.halt = 1'b1;
            end
          end
          if (r.halt) clear_run_controls();
          if (h >= 0) begin
            r.hit = 1'b1; r.hit_index = OUT_IDX_W'(h); r.hit_count = bp_hits[h];
          end
          if (a >= 0) begin
            r.alias_hit = 1'b1; r.alias_index = OUT_IDX_W'(a); r.alias_count = bp_hits[a];
          end
        end
      end
    endcase
    return r;
  endfunction

  // -------------------------------------------------------------- monitor

  task automatic flag_mismatch(input string what, input logic have_want,
                               input mon_result_t want, input mon_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (have_want)
        $display("[%0t] %s: want h=%0b t=%0b hit=%0b/%0d/%0d alias=%0b/%0d/%0d", $realtime, what,
                 want.halt, want.trace, want.hit, want.hit_index, want.hit_count,
                 want.alias_hit, want.alias_index, want.alias_count);
      $display("[%0t] %s:  got h=%0b t=%0b hit=%0b/%0d/%0d alias=%0b/%0d/%0d", $realtime, what,
               got.halt, got.trace, got.hit, got.hit_index, got.hit_count,
               got.alias_hit, got.alias_index, got.alias_count);
    end
  endtask

  always @(posedge clk) begin
    mon_result_t got;
    mon_result_t want;
    mon_result_t pred;
    logic        progress;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        bp_source[i] = '0; bp_kind[i] = KIND_DISABLED; bp_addr[i] = '0;
        bp_data[i] = '0; bp_dce[i] = 1'b0; bp_hits[i] = '0;
      end
      clear_run_controls();
      suppress_q = 1'b0;
      stall_cycles <= 0;
    end else begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        got = {halt, trace_request, hit, hit_index, hit_count,
               alias_hit, alias_index, alias_count};
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result", 1'b0, '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) flag_mismatch("result mismatch", 1'b1, want, got);
        end
        if (got.halt) n_halts++;
        if (got.trace) n_traces++;
        if (got.hit) n_hits++;
        if (got.alias_hit) n_alias++;
        if (got.hit_count == HITS_MAX || got.alias_count == HITS_MAX) n_sat++;
      end
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        suppress_q = cfg_data;
      end
      if (start && !busy) begin
        progress = 1'b1;
        pred = predict_monitor(cur_cmd);
        expected_results.push_back(cur_typed ? cur_want : pred);
        case (cur_cmd.op)
          OP_ACCESS:      n_access++;
          OP_WRITE_ENTRY: n_writes++;
          OP_ARM:         n_arms++;
          default:        n_stops++;
        endcase
      end
      stall_cycles <= progress ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("breakpoint_watchpoint_run_control verification failed");
    $finish;
  end

  // ------------------------------------------------------------- stimulus

  function automatic mon_cmd_t rand_fill();
    mon_cmd_t c;
    c.op          = op_t'($urandom_range(3));
    c.source      = SRC_W'($urandom_range(15));
    c.kind        = kind_t'($urandom_range(3));
    c.address     = ADDR_W'($urandom);
    c.data        = DATA_W'($urandom);
    c.dce         = 1'($urandom_range(1));
    c.entry_index = OUT_IDX_W'($urandom_range(15));
    c.mode        = run_mode_t'($urandom_range(3));
    c.value       = CNT_W'($urandom);
    return c;
  endfunction

  // unused fields stay random: the block must ignore them
  function automatic mon_cmd_t acc(input logic [SRC_W-1:0] s, input kind_t k,
                                   input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    mon_cmd_t c;
    c = rand_fill();
    c.op = OP_ACCESS; c.source = s; c.kind = k; c.address = a; c.data = d;
    return c;
  endfunction

  function automatic mon_cmd_t wr(input int idx, input logic [SRC_W-1:0] s, input kind_t k,
                                  input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                                  input logic dce);
    mon_cmd_t c;
    c = rand_fill();
    c.op = OP_WRITE_ENTRY; c.entry_index = OUT_IDX_W'(idx);
    c.source = s; c.kind = k; c.address = a; c.data = d; c.dce = dce;
    return c;
  endfunction

  function automatic mon_cmd_t arm(input logic [SRC_W-1:0] s, input run_mode_t m,
                                   input logic [CNT_W-1:0] v);
    mon_cmd_t c;
    c = rand_fill();
    c.op = OP_ARM; c.source = s; c.mode = m; c.value = v;
    return c;
  endfunction

  function automatic mon_cmd_t stop_cmd();
    mon_cmd_t c;
    c = rand_fill();
    c.op = OP_STOP_ALL;
    return c;
  endfunction

  function automatic mon_result_t res(input logic h, input logic t, input logic ph,
                                      input int pi, input int pc, input logic ah,
                                      input int ai, input int ac);
    mon_result_t r;
    r = '{h, t, ph, OUT_IDX_W'(pi), HITS_W'(pc), ah, OUT_IDX_W'(ai), HITS_W'(ac)};
    return r;
  endfunction

  task automatic add_row(input mon_cmd_t c, input logic sup, input int reps,
                         input logic typed, input mon_result_t want);
    dir_row_t r;
    r.cmd = c; r.sup = sup; r.reps = reps; r.typed = typed; r.want = want;
    dir_rows.push_back(r);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(9) < 8) return addr_pool[$urandom_range(3)];
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    if ($urandom_range(9) < 7) return data_pool[$urandom_range(2)];
    return DATA_W'($urandom);
  endfunction

  function automatic logic [SRC_W-1:0] pick_src();
    int r;
    r = $urandom_range(99);
    if (r < 45) return SRC_W'($urandom_range(1));
    if (r < 60) return SRC_APU;
    if (r < 90) return SRC_W'($urandom_range(8));
    return SRC_W'($urandom_range(15));
  endfunction

  // small address and data pools so entries, events and run targets meet often
  function automatic mon_cmd_t gen_random_cmd();
    mon_cmd_t c;
    int       r;
    c = rand_fill();
    r = $urandom_range(99);
    if (r < 62) begin
      c.op      = OP_ACCESS;
      c.source  = pick_src();
      c.kind    = ($urandom_range(9) < 4) ? KIND_EXEC : kind_t'($urandom_range(3));
      c.address = pick_addr();
      c.data    = pick_data();
    end else if (r < 82) begin
      c.op      = OP_WRITE_ENTRY;
      c.source  = pick_src();
      c.address = pick_addr();
      c.data    = pick_data();
    end else if (r < 96) begin
      c.op     = OP_ARM;
      c.source = ($urandom_range(9) == 0) ? SRC_W'($urandom_range(15))
                                          : SRC_W'($urandom_range(1));
      if ($urandom_range(9) == 0)
        c.value = CNT_W'($urandom);
      else if (c.mode == MODE_RUN_TO || c.mode == MODE_STEP_TO)
        c.value = CNT_W'(pick_addr());
      else
        c.value = CNT_W'($urandom_range(6));
    end else begin
      c.op = OP_STOP_ALL;
    end
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input mon_cmd_t c, input logic typed, input mon_result_t want,
                          input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    cur_cmd   <= c;
    cur_typed <= typed;
    cur_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_suppress(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    sup_now = v;
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cur_cmd    = '0;
    cur_typed  = 1'b0;
    cur_want   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    sup_now    = 1'b0;
    mismatches = 0;
    n_access = 0; n_writes = 0; n_arms = 0; n_stops = 0;
    n_halts = 0; n_traces = 0; n_hits = 0; n_alias = 0; n_sat = 0;

    // after reset the table is all disabled
    add_row(acc(SRC_CPU, KIND_EXEC, 24'h000000, 8'h00), 1'b0, 1, 1'b1, '0);
    add_row(acc(SRC_CPU, KIND_DISABLED, 24'hFFFFFF, 8'hFF), 1'b0, 1, 1'b1, '0);
    add_row(wr(0, SRC_CPU, KIND_EXEC, 24'hFFFFFF, 8'hFF, 1'b1), 1'b0, 1, 1'b1, '0);
    add_row(wr(15, SRC_SMP, KIND_WRITE, 24'h000000, 8'h00, 1'b1), 1'b0, 1, 1'b1, '0);
    add_row(wr(1, SRC_APU, KIND_WRITE, 24'h000000, 8'h00, 1'b1), 1'b0, 1, 1'b1, '0);
    // smp write hits its own entry and the audio RAM alias
    add_row(acc(SRC_SMP, KIND_WRITE, 24'h000000, 8'h00), 1'b0, 1, 1'b1,
            res(1, 0, 1, 15, 1, 1, 1, 1));
    add_row(acc(SRC_SMP, KIND_WRITE, 24'h000000, 8'h01), 1'b0, 1, 1'b0, '0);
    add_row(acc(SRC_CPU, KIND_EXEC, 24'hFFFFFF, 8'h00), 1'b0, 1, 1'b1,
            res(1, 1, 1, 0, 1, 0, 0, 0));
    // execute hit from a source with no run control: halt without trace
    add_row(wr(2, 4'd2, KIND_EXEC, 24'h123456, 8'h00, 1'b0), 1'b0, 1, 1'b0, '0);
    add_row(acc(4'd2, KIND_EXEC, 24'h123456, 8'h00), 1'b0, 1, 1'b0, '0);
    add_row(arm(SRC_CPU, MODE_RUN_FOR, 24'd3), 1'b0, 1, 1'b0, '0);
    add_row(arm(SRC_CPU, MODE_RUN_TO, 24'h000100), 1'b0, 1, 1'b0, '0);
    add_row(acc(SRC_CPU, KIND_EXEC, 24'h000010, 8'h00), 1'b0, 1, 1'b0, '0);
    add_row(acc(SRC_CPU, KIND_EXEC, 24'h000100, 8'h00), 1'b0, 1, 1'b0, '0);
    // step-for armed with zero wraps round
    add_row(arm(SRC_SMP, MODE_STEP_FOR, 24'd0), 1'b0, 1, 1'b0, '0);
    add_row(acc(SRC_SMP, KIND_EXEC, 24'h000005, 8'h00), 1'b0, 1, 1'b0, '0);
    add_row(arm(SRC_SMP, MODE_STEP_TO, 24'h000200), 1'b0, 1, 1'b0, '0);
    add_row(acc(SRC_SMP, KIND_EXEC, 24'h000200, 8'h00), 1'b0, 1, 1'b0, '0);
    // arming from a non-processor source is ignored
    add_row(arm(4'd2, MODE_RUN_FOR, 24'd1), 1'b0, 1, 1'b0, '0);
    add_row(acc(SRC_CPU, KIND_EXEC, 24'h000040, 8'h00), 1'b0, 1, 1'b0, '0);
    add_row(arm(SRC_CPU, MODE_STEP_FOR, 24'd1), 1'b0, 1, 1'b0, '0);
    add_row(stop_cmd(), 1'b0, 1, 1'b1, res(1, 0, 0, 0, 0, 0, 0, 0));
    add_row(acc(SRC_CPU, KIND_EXEC, 24'h000007, 8'h00), 1'b0, 1, 1'b0, '0);
    // repeated hits on one primary and one alias entry
    add_row(wr(3, SRC_SMP, KIND_READ, 24'hABCDEF, 8'h5A, 1'b0), 1'b0, 1, 1'b0, '0);
    add_row(wr(4, SRC_APU, KIND_READ, 24'hABCDEF, 8'h00, 1'b1), 1'b0, 1, 1'b0, '0);
    add_row(acc(SRC_SMP, KIND_READ, 24'hABCDEF, 8'h00), 1'b0, HIT_REPEATS, 1'b0, '0);
    // suppressed: events that would hit do nothing
    add_row(acc(SRC_CPU, KIND_EXEC, 24'hFFFFFF, 8'h00), 1'b1, 1, 1'b1, '0);
    add_row(acc(SRC_SMP, KIND_READ, 24'hABCDEF, 8'h00), 1'b1, 1, 1'b1, '0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    write_suppress(1'b0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].sup != sup_now) begin
        drain_results();
        write_suppress(dir_rows[i].sup);
      end
      repeat (dir_rows[i].reps)
        send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want, 0);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      write_suppress(PHASE_SUP[p]);
      addr_pool = '{24'h000000, 24'hFFFFFF, ADDR_W'($urandom), ADDR_W'($urandom)};
      data_pool = '{8'h00, 8'hFF, DATA_W'($urandom)};
      repeat (PHASE_ITEMS[p])
        send_cmd(gen_random_cmd(), 1'b0, '0, PHASE_IDLE[p]);
    end

    drain_results();
    repeat (ENTRIES + 4) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end

    $display("covered %0d access events, %0d entry writes, %0d arms, %0d stop-alls",
             n_access, n_writes, n_arms, n_stops);
    $display("seen %0d halts, %0d traces, %0d hits, %0d alias hits, %0d saturated counts",
             n_halts, n_traces, n_hits, n_alias, n_sat);
    if (mismatches == 0)
      $display("breakpoint_watchpoint_run_control verification clean");
    else
      $display("breakpoint_watchpoint_run_control verification failed");
    $finish;
  end

endmodule
